[hw/rtl/ps2kb_pkg.sv]
// Shared types, codes and translation tables for the scan code set 1 translator.
// No dependencies; imported by the translator top level and its checker.
`timescale 1ns / 1ps

package ps2kb_pkg;

  // Key kinds reported per step
  localparam logic [2:0] KIND_NONE      = 3'd0;
  localparam logic [2:0] KIND_CHAR      = 3'd1;
  localparam logic [2:0] KIND_BACKSPACE = 3'd2;
  localparam logic [2:0] KIND_ENTER     = 3'd3;
  localparam logic [2:0] KIND_TAB       = 3'd4;

  // Op codes of an input item
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Scan codes and keyboard replies
  localparam logic [7:0] CODE_CAPS_LOCK   = 8'h3A;
  localparam logic [7:0] CODE_NUM_LOCK    = 8'h45;
  localparam logic [7:0] CODE_SCROLL_LOCK = 8'h46;
  localparam logic [7:0] CODE_ACK         = 8'hFA;
  localparam logic [7:0] CODE_RESEND      = 8'hFE;
  localparam logic [7:0] CODE_LSHIFT_MAKE = 8'h2A;
  localparam logic [7:0] CODE_RSHIFT_MAKE = 8'h36;
  localparam logic [7:0] CODE_LSHIFT_BRK  = 8'hAA;
  localparam logic [7:0] CODE_RSHIFT_BRK  = 8'hB6;
  localparam logic [7:0] CODE_TAB         = 8'h0F;
  localparam logic [7:0] CODE_BACKSPACE   = 8'h0E;
  localparam logic [7:0] CODE_ENTER       = 8'h1C;
  localparam logic [7:0] CODE_TABLE_LIMIT = 8'h54;

  localparam logic [7:0] LED_CMD = 8'hED;

  localparam logic [2:0] LED_CAPS   = 3'b100;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_SCROLL = 3'b001;

  localparam logic [6:0] CASE_BIT = 7'h20;

  localparam int MAP_SIZE = 84;

  localparam logic [6:0] PLAIN_MAP [0:MAP_SIZE-1] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h00,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h00, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B,
    7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C,
    7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
    7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h37, 7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B,
    7'h31, 7'h32, 7'h33, 7'h30, 7'h2E
  };

  localparam logic [6:0] SHIFT_MAP [0:MAP_SIZE-1] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h00,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B,
    7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C,
    7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
    7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h37, 7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B,
    7'h31, 7'h32, 7'h33, 7'h30, 7'h2E
  };

  typedef struct packed {
    logic [2:0] key_kind;
    logic [6:0] char_code;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [2:0] lock_leds;
    logic       queue_overflow;
  } result_t;

  // Table lookup plus caps inversion; code must be below the table limit
  function automatic logic [6:0] xlate(input logic [6:0] code, input logic shifted,
                                       input logic caps);
    logic [6:0] c;
    logic       letter;
    c = shifted ? SHIFT_MAP[code] : PLAIN_MAP[code];
    letter = ((c >= 7'h61) && (c <= 7'h7A)) || ((c >= 7'h41) && (c <= 7'h5A));
    if (caps && letter) begin
      c = c ^ CASE_BIT;
    end
    return c;
  endfunction

endpackage

[hw/rtl/ps2_keyboard_scancode_translator.sv]
// Scan code set 1 translator: shift/lock tracking, ASCII lookup, LED command queue.
// Depends on ps2kb_pkg and ps2kb_ram (two banks of the command queue).
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   in      | input     | in_valid/in_ready  | op, scan_code
//   out     | output    | out_valid/out_ready| key_kind, char_code, tx_valid, tx_byte,
//           |           |                    | lock_leds, queue_overflow
//   cfg     | APB       | psel/penable       | initial_lock_leds at byte address 0
//
// One item per cycle: each item is handled in the cycle it is accepted and its
// result lands in the output buffer on that edge. The queue head is prefetched
// from the RAM banks every cycle, with a forward of the write made on the same edge.
// A two-entry output buffer keeps in_ready high while one result waits; the input
// stalls only when both entries are full. Reset is synchronous and empties the queue
// without touching the RAM; no clearing pass is needed.
`timescale 1ns / 1ps

module ps2_keyboard_scancode_translator
  import ps2kb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  scan_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  key_kind,
  output logic [6:0]  char_code,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic [2:0]  lock_leds,
  output logic        queue_overflow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Physical ring is a power of two of at least four, split into even/odd banks
  localparam int PTR_W      = ($clog2(QUEUE_DEPTH) > 2) ? $clog2(QUEUE_DEPTH) : 2;
  localparam int BANK_AW    = PTR_W - 1;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int COUNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_W-1:0] CNT_DEPTH    = COUNT_W'(QUEUE_DEPTH);
  localparam logic [COUNT_W-1:0] CNT_DEPTH_M1 = COUNT_W'(QUEUE_DEPTH - 1);
  localparam logic               REG_INIT_LEDS = 1'b0;

  // Architectural state
  logic [2:0]         init_leds;
  logic               shift_held;
  logic [2:0]         led_bits;
  logic               awaiting_ack;
  logic [7:0]         pending_byte;
  logic [PTR_W-1:0]   queue_head;
  logic [COUNT_W-1:0] queue_count;

  logic               shift_held_next;
  logic [2:0]         led_bits_next;
  logic               awaiting_ack_next;
  logic [7:0]         pending_byte_next;
  logic [PTR_W-1:0]   queue_head_next;
  logic [COUNT_W-1:0] queue_count_next;

  // Head prefetch forwarding
  logic               fwd_valid;
  logic [7:0]         fwd_data;
  logic               fwd_valid_next;
  logic [7:0]         fwd_data_next;

  // Output buffer
  result_t            out_main;
  result_t            out_skid;
  logic               skid_valid;

  logic               accept;
  logic               out_xfer;
  result_t            res;

  logic [PTR_W-1:0]   head0;
  logic [COUNT_W-1:0] cnt0;
  logic [COUNT_W-1:0] cnt1;
  logic [PTR_W-1:0]   tail0;
  logic [PTR_W-1:0]   tail1;
  logic               push_pair;
  logic               push0;
  logic               push1;
  logic               pop;
  logic [7:0]         pop_byte;
  logic [7:0]         head_data;
  logic [7:0]         led_byte;
  logic [6:0]         ch;

  logic               bank_we    [2];
  logic [BANK_AW-1:0] bank_waddr [2];
  logic [7:0]         bank_wdata [2];
  logic [7:0]         bank_rdata [2];
  logic [PTR_W-1:0]   rd_ptr;

  assign accept   = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign in_ready = !skid_valid;

  assign head_data = fwd_valid ? fwd_data : bank_rdata[queue_head[0]];

  always_comb begin
    shift_held_next   = shift_held;
    led_bits_next     = led_bits;
    awaiting_ack_next = awaiting_ack;
    pending_byte_next = pending_byte;
    head0             = queue_head;
    cnt0              = queue_count;
    push_pair         = 1'b0;
    res               = '0;
    ch                = 7'd0;

    if (op == OP_START) begin
      led_bits_next     = init_leds;
      shift_held_next   = 1'b0;
      awaiting_ack_next = 1'b0;
      head0             = '0;
      cnt0              = '0;
      push_pair         = 1'b1;
    end else begin
      unique case (scan_code)
        CODE_CAPS_LOCK: begin
          led_bits_next = led_bits ^ LED_CAPS;
          push_pair     = 1'b1;
        end
        CODE_NUM_LOCK: begin
          led_bits_next = led_bits ^ LED_NUM;
          push_pair     = 1'b1;
        end
        CODE_SCROLL_LOCK: begin
          led_bits_next = led_bits ^ LED_SCROLL;
          push_pair     = 1'b1;
        end
        CODE_ACK: awaiting_ack_next = 1'b0;
        CODE_RESEND: begin
          if (awaiting_ack) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = pending_byte;
          end
        end
        CODE_LSHIFT_MAKE, CODE_RSHIFT_MAKE: shift_held_next = 1'b1;
        CODE_LSHIFT_BRK, CODE_RSHIFT_BRK:   shift_held_next = 1'b0;
        CODE_TAB:       res.key_kind = KIND_TAB;
        CODE_BACKSPACE: res.key_kind = KIND_BACKSPACE;
        CODE_ENTER:     res.key_kind = KIND_ENTER;
        default: begin
          if (scan_code < CODE_TABLE_LIMIT) begin
            ch = xlate(scan_code[6:0], shift_held, (led_bits & LED_CAPS) != 3'b000);
            res.char_code = ch;
            res.key_kind  = (ch != 7'd0) ? KIND_CHAR : KIND_NONE;
          end
        end
      endcase
    end

    // Push the LED pair; the LED byte is lost when only one place is left
    led_byte = {5'b0, led_bits_next};
    push0    = push_pair && (cnt0 < CNT_DEPTH);
    push1    = push_pair && (cnt0 < CNT_DEPTH_M1);
    res.queue_overflow = push_pair && !push1;
    cnt1  = cnt0 + COUNT_W'(push0) + COUNT_W'(push1);
    tail0 = head0 + PTR_W'(cnt0);
    tail1 = tail0 + PTR_W'(1);

    // Send the head byte; an empty queue before the push means it is the command
    pop      = !awaiting_ack_next && (cnt1 != '0);
    pop_byte = (cnt0 == '0) ? LED_CMD : head_data;
    queue_head_next  = head0;
    queue_count_next = cnt1;
    if (pop) begin
      pending_byte_next = pop_byte;
      queue_head_next   = head0 + PTR_W'(1);
      queue_count_next  = cnt1 - COUNT_W'(1);
      awaiting_ack_next = 1'b1;
      res.tx_valid      = 1'b1;
      res.tx_byte       = pop_byte;
    end
    res.lock_leds = led_bits_next;
  end

  // Bank tail0[0] takes the command byte, the other bank the LED byte
  always_comb begin
    bank_we[0]    = accept && (tail0[0] ? push1 : push0);
    bank_waddr[0] = tail0[0] ? tail1[PTR_W-1:1] : tail0[PTR_W-1:1];
    bank_wdata[0] = tail0[0] ? led_byte : LED_CMD;
    bank_we[1]    = accept && (tail0[0] ? push0 : push1);
    bank_waddr[1] = tail0[0] ? tail0[PTR_W-1:1] : tail1[PTR_W-1:1];
    bank_wdata[1] = tail0[0] ? LED_CMD : led_byte;

    rd_ptr         = accept ? queue_head_next : queue_head;
    fwd_valid_next = bank_we[rd_ptr[0]] && (bank_waddr[rd_ptr[0]] == rd_ptr[PTR_W-1:1]);
    fwd_data_next  = bank_wdata[rd_ptr[0]];
  end

  for (genvar b = 0; b < 2; b++) begin : g_bank
    ps2kb_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (bank_waddr[b]),
      .wdata (bank_wdata[b]),
      .raddr (rd_ptr[PTR_W-1:1]),
      .rdata (bank_rdata[b])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held   <= 1'b0;
      led_bits     <= 3'b000;
      awaiting_ack <= 1'b0;
      pending_byte <= 8'h00;
      queue_head   <= '0;
      queue_count  <= '0;
      fwd_valid    <= 1'b0;
    end else begin
      fwd_valid <= fwd_valid_next;
      if (accept) begin
        shift_held   <= shift_held_next;
        led_bits     <= led_bits_next;
        awaiting_ack <= awaiting_ack_next;
        pending_byte <= pending_byte_next;
        queue_head   <= queue_head_next;
        queue_count  <= queue_count_next;
      end
    end
    fwd_data <= fwd_data_next;
  end

  // Two-entry output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_xfer) begin
        if (skid_valid) begin
          out_main   <= out_skid;
          skid_valid <= 1'b0;
        end else if (accept) begin
          out_main <= res;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid) begin
          out_main  <= res;
          out_valid <= 1'b1;
        end else begin
          out_skid   <= res;
          skid_valid <= 1'b1;
        end
      end
    end
  end

  assign key_kind       = out_main.key_kind;
  assign char_code      = out_main.char_code;
  assign tx_valid       = out_main.tx_valid;
  assign tx_byte        = out_main.tx_byte;
  assign lock_leds      = out_main.lock_leds;
  assign queue_overflow = out_main.queue_overflow;

  // Configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      init_leds <= 3'b000;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_INIT_LEDS)) begin
      init_leds <= pwdata[2:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_INIT_LEDS) ? {29'b0, init_leds} : 32'h0;

endmodule

[hw/rtl/ps2kb_ram.sv]
// Generic single-write, single-read RAM with registered read data (read-old).
// No dependencies.
`timescale 1ns / 1ps

module ps2kb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/ps2kb_checker.sv]
// Port-level checks for the scan code translator, bound onto its top level.
// Depends on ps2kb_pkg and ps2_keyboard_scancode_translator.
`timescale 1ns / 1ps

module ps2kb_checker
  import ps2kb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  key_kind,
  input logic [6:0]  char_code,
  input logic        tx_valid,
  input logic [7:0]  tx_byte,
  input logic [2:0]  lock_leds,
  input logic        queue_overflow
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(key_kind) && $stable(char_code)
      && $stable(tx_byte) && $stable(lock_leds) && $stable(queue_overflow))
    else $error("result changed while stalled");

  // Input stalls only while a result waits and a second one is buffered
  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  a_char_only_for_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && (key_kind != KIND_CHAR) |-> (char_code == 7'd0))
    else $error("character code without character kind");

  a_tx_byte_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_valid |-> (tx_byte == 8'h00))
    else $error("transmit byte set without transfer to keyboard");

endmodule

bind ps2_keyboard_scancode_translator ps2kb_checker u_ps2kb_checker (.*);

[test/tb.sv]
// Self-checking bench for ps2_keyboard_scancode_translator: scan code bytes in, key reports out.
// Predicts shift/lock tracking, ASCII lookup and the LED command queue; needs ps2kb_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import ps2kb_pkg::*;

  localparam int QUEUE_SLOTS = 16;
  localparam int SLOT_W = $clog2(QUEUE_SLOTS);
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [2:0] REG_INITIAL_LOCK_LEDS = 3'd0;

  // Scan code set 1 to ASCII, unshifted and shifted; zero means no character
  localparam logic [6:0] KEYS_PLAIN [0:83] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
    7'h2D, 7'h3D, 7'h00, 7'h00, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h00, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68,
    7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31, 7'h32, 7'h33, 7'h30, 7'h2E
  };
  localparam logic [6:0] KEYS_SHIFTED [0:83] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
    7'h5F, 7'h2B, 7'h08, 7'h00, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48,
    7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31, 7'h32, 7'h33, 7'h30, 7'h2E
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = OP_BYTE;
  logic [7:0]  scan_code = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  key_kind;
  logic [6:0]  char_code;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic [2:0]  lock_leds;
  logic        queue_overflow;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Keyboard state as the block should hold it
  logic [2:0] start_leds = 3'd0;
  logic       shift_down = 1'b0;
  logic [2:0] led_state = 3'd0;
  logic       ack_wait = 1'b0;
  logic [7:0] last_sent = 8'h00;
  logic [7:0] kbd_cmd_fifo [QUEUE_SLOTS];
  int         fifo_head = 0;
  int         fifo_count = 0;

  result_t due_reports[$];
  int      mismatches = 0;
  int      items_sent = 0;
  int      tx_idle_pct = 0;
  int      rx_stall_pct = 0;
  int      rx_hold = 0;
  int      ack_odds = 50;

  ps2_keyboard_scancode_translator #(.QUEUE_DEPTH(QUEUE_SLOTS)) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic queue_cmd_byte(input logic [7:0] b);
    if (fifo_count >= QUEUE_SLOTS) begin
      return 1'b0;
    end
    kbd_cmd_fifo[SLOT_W'((fifo_head + fifo_count) % QUEUE_SLOTS)] = b;
    fifo_count++;
    return 1'b1;
  endfunction

  // Queue LED command and LED byte; returns 1 if either was dropped
  function automatic logic queue_led_update();
    logic cmd_ok;
    logic led_ok;
    cmd_ok = queue_cmd_byte(LED_CMD);
    led_ok = queue_cmd_byte({5'b0, led_state});
    return !(cmd_ok && led_ok);
  endfunction

  function automatic result_t keyboard_step(input logic item_op, input logic [7:0] code);
    result_t    r;
    logic [6:0] ch;
    r = '0;
    if (item_op == OP_START) begin
      led_state = start_leds;
      shift_down = 1'b0;
      ack_wait = 1'b0;
      fifo_head = 0;
      fifo_count = 0;
      r.queue_overflow = queue_led_update();
    end else begin
      case (code)
        CODE_CAPS_LOCK: begin
          led_state ^= LED_CAPS;
          r.queue_overflow = queue_led_update();
        end
        CODE_NUM_LOCK: begin
          led_state ^= LED_NUM;
          r.queue_overflow = queue_led_update();
        end
        CODE_SCROLL_LOCK: begin
          led_state ^= LED_SCROLL;
          r.queue_overflow = queue_led_update();
        end
        CODE_ACK: ack_wait = 1'b0;
        CODE_RESEND: begin
          if (ack_wait) begin
            r.tx_valid = 1'b1;
            r.tx_byte = last_sent;
          end
        end
        CODE_LSHIFT_MAKE, CODE_RSHIFT_MAKE: shift_down = 1'b1;
        CODE_LSHIFT_BRK, CODE_RSHIFT_BRK: shift_down = 1'b0;
        CODE_TAB: r.key_kind = KIND_TAB;
        CODE_BACKSPACE: r.key_kind = KIND_BACKSPACE;
        CODE_ENTER: r.key_kind = KIND_ENTER;
        default: begin
          if (code < CODE_TABLE_LIMIT) begin
            ch = shift_down ? KEYS_SHIFTED[code[6:0]] : KEYS_PLAIN[code[6:0]];
            // caps lock flips letters only
            if ((led_state & LED_CAPS) != 3'b000 &&
                ((ch >= 7'h61 && ch <= 7'h7A) || (ch >= 7'h41 && ch <= 7'h5A))) begin
              ch ^= CASE_BIT;
            end
            r.char_code = ch;
            if (ch != 7'd0) begin
              r.key_kind = KIND_CHAR;
            end
          end
        end
      endcase
    end
    // advance the command queue unless the keyboard still owes an ack
    if (!ack_wait && fifo_count != 0) begin
      last_sent = kbd_cmd_fifo[SLOT_W'(fifo_head)];
      fifo_head = (fifo_head + 1) % QUEUE_SLOTS;
      fifo_count--;
      ack_wait = 1'b1;
      r.tx_valid = 1'b1;
      r.tx_byte = last_sent;
    end
    r.lock_leds = led_state;
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%02h, actual 0x%02h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : report_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_reports.size() == 0) begin
        $display("%0t ns: report with none due, expected nothing, actual kind %0d char 0x%02h",
                 $time, key_kind, char_code);
        mismatches++;
      end else begin
        want = due_reports.pop_front();
        check_field("key_kind", 8'(want.key_kind), 8'(key_kind));
        check_field("char_code", 8'(want.char_code), 8'(char_code));
        check_field("tx_valid", 8'(want.tx_valid), 8'(tx_valid));
        check_field("tx_byte", want.tx_byte, tx_byte);
        check_field("lock_leds", 8'(want.lock_leds), 8'(lock_leds));
        check_field("queue_overflow", 8'(want.queue_overflow), 8'(queue_overflow));
      end
    end
  end

  // Output back-pressure in bursts
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= (rx_hold == 1);
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      rx_hold <= $urandom_range(1, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("status: fail");
    $finish;
  end

  // Call at a rising edge; returns at the edge where the item transfers
  task automatic send_item(input logic item_op, input logic [7:0] code);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= item_op;
    scan_code <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    due_reports.push_back(keyboard_step(item_op, code));
    items_sent++;
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
  endtask

  // Write the start LED register, then read it back
  task automatic set_start_leds(input logic [2:0] leds);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_INITIAL_LOCK_LEDS;
    pwdata <= 32'(leds);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    start_leds = leds;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[2:0] !== leds) begin
      $display("%0t ns: initial_lock_leds readback mismatch, expected %03b, actual %03b",
               $time, leds, prdata[2:0]);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_random_stroke();
    int         pick;
    int         n;
    logic [7:0] key;
    if (ack_wait && $urandom_range(0, 99) < ack_odds) begin
      send_item(OP_BYTE, CODE_ACK);
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      key = 8'($urandom_range(0, 8'h53));
      send_item(OP_BYTE, key);
      send_item(OP_BYTE, key | 8'h80);
    end else if (pick < 55) begin
      send_item(OP_BYTE, $urandom_range(0, 1) ? CODE_LSHIFT_MAKE : CODE_RSHIFT_MAKE);
      n = $urandom_range(1, 3);
      repeat (n) begin
        key = 8'($urandom_range(0, 8'h53));
        send_item(OP_BYTE, key);
        send_item(OP_BYTE, key | 8'h80);
      end
      send_item(OP_BYTE, $urandom_range(0, 1) ? CODE_LSHIFT_BRK : CODE_RSHIFT_BRK);
    end else if (pick < 67) begin
      case ($urandom_range(0, 2))
        0: key = CODE_CAPS_LOCK;
        1: key = CODE_NUM_LOCK;
        default: key = CODE_SCROLL_LOCK;
      endcase
      send_item(OP_BYTE, key);
      send_item(OP_BYTE, key | 8'h80);
    end else if (pick < 77) begin
      send_item(OP_BYTE, CODE_ACK);
    end else if (pick < 84) begin
      send_item(OP_BYTE, CODE_RESEND);
    end else if (pick < 86) begin
      send_item(OP_START, 8'($urandom));
    end else begin
      // noise: any byte at all
      send_item(OP_BYTE, 8'($urandom));
    end
  endtask

  task automatic test_directed_keys();
    set_start_leds(3'b111);
    send_item(OP_START, 8'hFF);
    send_item(OP_BYTE, CODE_RESEND);
    send_item(OP_BYTE, CODE_ACK);
    send_item(OP_BYTE, CODE_ACK);
    send_item(OP_BYTE, CODE_RESEND);
    send_item(OP_BYTE, 8'h10);
    send_item(OP_BYTE, CODE_LSHIFT_MAKE);
    send_item(OP_BYTE, 8'h10);
    send_item(OP_BYTE, 8'h02);
    send_item(OP_BYTE, CODE_BACKSPACE);
    send_item(OP_BYTE, CODE_ENTER);
    send_item(OP_BYTE, CODE_TAB);
    send_item(OP_BYTE, CODE_LSHIFT_BRK);
    send_item(OP_BYTE, 8'h53);
    send_item(OP_BYTE, CODE_TABLE_LIMIT);
    send_item(OP_BYTE, 8'hFF);
  endtask

  // Lock keys with no acks: fill the queue, lose one LED byte, then a whole pair
  task automatic test_lock_overflow();
    logic [7:0] lock_codes [3];
    lock_codes = '{CODE_CAPS_LOCK, CODE_NUM_LOCK, CODE_SCROLL_LOCK};
    for (int i = 0; i < 10; i++) begin
      send_item(OP_BYTE, lock_codes[i % 3]);
    end
    drain_reports();
  endtask

  task automatic test_random_phases();
    logic [2:0] leds;
    int         phase_end;
    for (int p = 0; p < 6; p++) begin
      drain_reports();
      leds = (p == 0) ? 3'b000 : (p == 1) ? 3'b111 : 3'($urandom_range(0, 7));
      set_start_leds(leds);
      tx_idle_pct = (p % 3 == 1) ? 0 : 30;
      rx_stall_pct = (p % 3 == 1) ? 0 : 15;
      ack_odds = p[0] ? 70 : 10;
      send_item(OP_START, 8'($urandom));
      phase_end = items_sent + 200;
      while (items_sent < phase_end) begin
        send_random_stroke();
        // hold off now and then until every report is in
        if ($urandom_range(0, 149) == 0) begin
          drain_reports();
        end
      end
    end
  endtask

  task automatic test_steady_tail();
    int tail_end;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    ack_odds = 50;
    tail_end = items_sent + 180;
    while (items_sent < tail_end) begin
      send_random_stroke();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed_keys();
    test_lock_overflow();
    test_random_phases();
    test_steady_tail();
    drain_reports();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
